// ----- rtl/trmt_pkg.sv -----
// Package for the track id remap table.
// Holds table sizing, key layout, status codes, the controller state type and
// the request structs passed to the key memory. No dependencies.
`default_nettype none

package trmt_pkg;

  // Table sizing
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Key layout: subtype in the upper bits, source id in the lower bits
  localparam int SUBTYPE_W = 16;
  localparam int ID_W      = 32;
  localparam int KEY_W     = SUBTYPE_W + ID_W;
  localparam int STATUS_W  = 3;

  typedef logic [KEY_W-1:0] key_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND   = 3'd0,
    STAT_NEW     = 3'd1,
    STAT_MISSING = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_BYPASS  = 3'd4
  } status_t;

  // Item op codes
  typedef enum logic {
    OP_ACTIVE     = 1'b0,
    OP_TERMINATED = 1'b1
  } op_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Key memory write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    key_t             key;
  } key_wr_t;

  // Key memory read request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } key_rd_t;

endpackage : trmt_pkg

`default_nettype wire

// ----- rtl/trmt_key_ram.sv -----
// Key store of the track id remap table: one write port, one read port,
// read data registered. Depends on trmt_pkg.
`default_nettype none

module trmt_key_ram
  import trmt_pkg::*;
(
  input  wire logic    clk,
  input  wire key_wr_t wr_req,
  input  wire key_rd_t rd_req,
  output key_t         rd_key
);

  key_t mem [TABLE_ENTRIES];
  key_t rd_key_r;

  // Write a new key
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.key;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_key_r <= mem[rd_req.addr];
    end
  end

  assign rd_key = rd_key_r;

endmodule : trmt_key_ram

`default_nettype wire

// ----- rtl/track_id_remap_table.sv -----
// Track id remap table: maps (subtype, source id) keys to unique global ids.
// When bypassed, the item is echoed with status BYPASS; otherwise a linear search
// reads one key store entry per cycle from slot 0 and ends at the first match or
// after all entries_used entries on a miss (new, missing or full). While an item
// is searched, busy is high; a bypassed item does not raise busy.
// Synchronous active-low reset empties the table and clears bypass; no clear pass.
`default_nettype none

module track_id_remap_table
  import trmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Item input
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_op,
  input  wire logic [SUBTYPE_W-1:0] in_subtype,
  input  wire logic [ID_W-1:0]      in_input_id,
  // Result output
  output logic                      out_valid,
  output logic [ID_W-1:0]           out_id,
  output logic [STATUS_W-1:0]       out_status,
  // Configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_remap_disabled
);

  state_t            state_r, state_nxt;
  logic              bypass_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  key_t              key_r, key_nxt;
  logic              op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  status_t           out_status_r, out_status_nxt;

  key_wr_t           wr_req;
  key_rd_t           rd_req;
  key_t              rd_key;
  logic              hit;
  logic              scan_end;

  trmt_key_ram u_key_ram (
    .clk    (clk),
    .wr_req (wr_req),
    .rd_req (rd_req),
    .rd_key (rd_key)
  );

  assign hit      = pend_r && (rd_key == key_r);
  assign scan_end = (addr_r == used_r);

  // Next state, key memory requests and result
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    addr_nxt       = addr_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    key_nxt        = key_r;
    op_nxt         = op_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    wr_req         = '0;
    rd_req         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (bypass_r) begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = in_input_id;
            out_status_nxt = STAT_BYPASS;
          end else begin
            key_nxt   = {in_subtype, in_input_id};
            op_nxt    = in_op;
            addr_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue the next read while comparing the previous one
        if (!scan_end) begin
          rd_req.en    = 1'b1;
          rd_req.addr  = addr_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = addr_r[IDX_W-1:0];
          addr_nxt     = addr_r + CNT_W'(1);
        end
        priority if (hit) begin
          pend_nxt       = 1'b0;
          out_valid_nxt  = 1'b1;
          out_id_nxt     = ID_W'({1'b0, pend_idx_r} + (IDX_W + 1)'(1));
          out_status_nxt = STAT_FOUND;
          state_nxt      = S_IDLE;
        end else if (scan_end) begin
          // All used entries searched without a match
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          priority if (op_r == OP_TERMINATED) begin
            out_id_nxt     = '0;
            out_status_nxt = STAT_MISSING;
          end else if (used_r == CNT_W'(TABLE_ENTRIES)) begin
            out_id_nxt     = '0;
            out_status_nxt = STAT_FULL;
          end else begin
            wr_req.en      = 1'b1;
            wr_req.addr    = used_r[IDX_W-1:0];
            wr_req.key     = key_r;
            used_nxt       = used_r + CNT_W'(1);
            out_id_nxt     = ID_W'(used_r + CNT_W'(1));
            out_status_nxt = STAT_NEW;
          end
        end else begin
          // keep scanning
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r    <= 1'b0;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bypass_r <= cfg_remap_disabled;
      end
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    pend_idx_r   <= pend_idx_nxt;
    key_r        <= key_nxt;
    op_r         <= op_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;

endmodule : track_id_remap_table

`default_nettype wire
